// File: rtl/cbm_pkg.sv
package cbm_pkg;

    // Fixed field widths
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PHYS_W     = 23;
    localparam int unsigned ROM_BANK_W = 9;
    localparam int unsigned RAM_BANK_W = 8;
    localparam int unsigned SEL_W      = 4;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    // Clock register file
    localparam int unsigned CLOCK_REGS  = 5;
    localparam int unsigned CLK_IDX_W   = $clog2(CLOCK_REGS);

    // Mapper kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ONE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TWO   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_THREE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIVE  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_CLOCK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_MOTOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ALLOWED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MASK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ROM       = 3'd6;

    // Address map regions, by bus_address[15:13]
    localparam logic [2:0] REG_RAM_EN   = 3'd0;
    localparam logic [2:0] REG_ROM_BANK = 3'd1;
    localparam logic [2:0] REG_RAM_BANK = 3'd2;
    localparam logic [2:0] REG_MODE     = 3'd3;
    localparam logic [2:0] REG_EXT_RAM  = 3'd5;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [ADDR_W-1:0] KIND_TWO_BANK_ADDR = 16'h2100;

    // Result kinds
    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_ROM_RD    = 3'd1,
        TGT_RAM_RD    = 3'd2,
        TGT_RAM_WR    = 3'd3,
        TGT_CLK_RD    = 3'd4,
        TGT_CLK_WR    = 3'd5,
        TGT_DISABLED  = 3'd6,
        TGT_CTRL_WR   = 3'd7
    } target_t;

    // Clock register select codes
    localparam logic [CLK_IDX_W-1:0] SEL_SEC  = 3'd0;
    localparam logic [CLK_IDX_W-1:0] SEL_MIN  = 3'd1;
    localparam logic [CLK_IDX_W-1:0] SEL_HOUR = 3'd2;

    // byte mod 60: quotient by reciprocal 274/2^14, exact for 0..255
    function automatic logic [BYTE_W-1:0] mod60(input logic [BYTE_W-1:0] v);
        logic [16:0] prod;
        logic [2:0]  q;
        logic [8:0]  qm;
        prod = 17'(v) * 17'd274;
        q    = prod[16:14];
        qm   = 9'(q) * 9'd60;
        return BYTE_W'(9'(v) - qm);
    endfunction

    // byte mod 24: quotient by reciprocal 171/2^12, exact for 0..255
    function automatic logic [BYTE_W-1:0] mod24(input logic [BYTE_W-1:0] v);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [8:0]  qm;
        prod = 16'(v) * 16'd171;
        q    = prod[15:12];
        qm   = 9'(q) * 9'd24;
        return BYTE_W'(9'(v) - qm);
    endfunction

endpackage

// File: rtl/cartridge_bank_mapper.sv
// Cartridge bank mapper: decodes one processor bus access per transfer.
// Channels: input (in_valid/in_ready, func, bus_address, write_byte),
// result (out_valid/out_ready, target, phys_address, read_byte, motor_on)
// and a configuration write channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) that is always ready and must only be used while idle.
// Each access is captured in an input register; once the output register
// is free or being emptied, the bank state is read and updated and the
// result is loaded into the output register. Throughput is one access per
// cycle while the receiver does not stall, set by the single decode stage.
// When the receiver stalls, the output register holds its result and the
// input register holds the next access; in_ready drops only when both are
// full. Reset empties both stages, loads the default configuration
// (mask on ROM bank all ones, everything else zero) and the bank state
// (ROM bank one, RAM disabled, clock registers zero, motor off).
module cartridge_bank_mapper
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [cbm_pkg::ADDR_W-1:0]         bus_address,
    input  logic [cbm_pkg::BYTE_W-1:0]         write_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         target,
    output logic [cbm_pkg::PHYS_W-1:0]         phys_address,
    output logic [cbm_pkg::BYTE_W-1:0]         read_byte,
    output logic                               motor_on,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cbm_pkg::*;

    // Configuration registers
    logic [KIND_W-1:0]     mapper_kind_reg;
    logic                  has_clock_reg;
    logic                  has_motor_reg;
    logic                  motor_allowed_reg;
    logic [ROM_BANK_W-1:0] rom_bank_mask_reg;
    logic [RAM_BANK_W-1:0] ram_bank_mask_reg;
    logic                  big_rom_reg;

    // Input stage
    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;

    // Output stage
    logic                  out_valid_reg;
    target_t               target_reg;
    logic [PHYS_W-1:0]     phys_reg;
    logic [BYTE_W-1:0]     read_byte_reg;
    logic                  motor_out_reg;

    // Bank state
    logic                  ram_enabled_reg, ram_enabled_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  wide_mode_reg, wide_mode_next;
    logic [BYTE_W-1:0]     low_half_reg, low_half_next;
    logic                  high_bit_reg, high_bit_next;
    logic [SEL_W-1:0]      clock_sel_reg, clock_sel_next;
    logic                  latch_last_reg, latch_last_next;
    logic                  motor_flag_reg, motor_flag_next;
    logic [BYTE_W-1:0]     clock_regs_reg [CLOCK_REGS];
    logic [BYTE_W-1:0]     clock_held_reg [CLOCK_REGS];

    // Combinational result and side effects
    target_t               target_next;
    logic [PHYS_W-1:0]     phys_next;
    logic [BYTE_W-1:0]     read_byte_next;
    logic                  clk_wr_en;
    logic [BYTE_W-1:0]     clk_wr_data;
    logic                  latch_en;

    logic                  advance;
    logic [2:0]            region;
    logic [CLK_IDX_W-1:0]  sel;
    logic                  sel_ok;
    logic                  clock_mapped;
    logic [ROM_BANK_W-1:0] five_bank;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign region       = s1_addr_reg[15:13];
    assign sel          = clock_sel_reg[CLK_IDX_W-1:0];
    assign sel_ok       = 32'(sel) < CLOCK_REGS;
    assign clock_mapped = has_clock_reg && clock_sel_reg[3];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_kind_reg   <= KIND_NONE;
            has_clock_reg     <= 1'b0;
            has_motor_reg     <= 1'b0;
            motor_allowed_reg <= 1'b0;
            rom_bank_mask_reg <= '1;
            ram_bank_mask_reg <= '0;
            big_rom_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAPPER_KIND:   mapper_kind_reg   <= cfg_data[KIND_W-1:0];
                CFG_HAS_CLOCK:     has_clock_reg     <= cfg_data[0];
                CFG_HAS_MOTOR:     has_motor_reg     <= cfg_data[0];
                CFG_MOTOR_ALLOWED: motor_allowed_reg <= cfg_data[0];
                CFG_ROM_BANK_MASK: rom_bank_mask_reg <= cfg_data[ROM_BANK_W-1:0];
                CFG_RAM_BANK_MASK: ram_bank_mask_reg <= cfg_data[RAM_BANK_W-1:0];
                CFG_BIG_ROM:       big_rom_reg       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg <= func;
            s1_addr_reg <= bus_address;
            s1_byte_reg <= write_byte;
        end
    end

    // Access decode and bank state update
    always_comb
    begin
        ram_enabled_next = ram_enabled_reg;
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        wide_mode_next   = wide_mode_reg;
        low_half_next    = low_half_reg;
        high_bit_next    = high_bit_reg;
        clock_sel_next   = clock_sel_reg;
        latch_last_next  = latch_last_reg;
        motor_flag_next  = motor_flag_reg;
        target_next      = TGT_NONE;
        phys_next        = '0;
        read_byte_next   = '0;
        clk_wr_en        = 1'b0;
        clk_wr_data      = '0;
        latch_en         = 1'b0;
        five_bank        = '0;

        if (!s1_func_reg)
        begin
            // Reads
            if (!s1_addr_reg[15])
            begin
                target_next = TGT_ROM_RD;
                if (!s1_addr_reg[14])
                    phys_next = PHYS_W'(s1_addr_reg);
                else
                    phys_next = {rom_bank_reg, s1_addr_reg[13:0]};
            end
            else if (region == REG_EXT_RAM)
            begin
                if (!ram_enabled_reg)
                begin
                    target_next    = TGT_DISABLED;
                    read_byte_next = '1;
                end
                else if (clock_mapped)
                begin
                    target_next    = TGT_CLK_RD;
                    read_byte_next = sel_ok ? clock_held_reg[sel] : '1;
                end
                else
                begin
                    target_next = TGT_RAM_RD;
                    phys_next   = PHYS_W'({ram_bank_reg, s1_addr_reg[12:0]});
                end
            end
        end
        else
        begin
            // Writes
            case (region)
                REG_RAM_EN:
                begin
                    target_next      = TGT_CTRL_WR;
                    ram_enabled_next = (s1_byte_reg[3:0] == RAM_EN_KEY);
                end
                REG_ROM_BANK:
                begin
                    target_next = TGT_CTRL_WR;
                    if (mapper_kind_reg == KIND_ONE || mapper_kind_reg == KIND_THREE ||
                        (mapper_kind_reg == KIND_TWO &&
                         s1_addr_reg == KIND_TWO_BANK_ADDR))
                    begin
                        rom_bank_next = (s1_byte_reg == '0) ? ROM_BANK_W'(1)
                                                            : ROM_BANK_W'(s1_byte_reg);
                    end
                    else if (mapper_kind_reg == KIND_FIVE)
                    begin
                        if (!s1_addr_reg[12])
                            low_half_next = s1_byte_reg;
                        else if (big_rom_reg)
                            high_bit_next = s1_byte_reg[0];
                        five_bank     = {high_bit_next, low_half_next};
                        rom_bank_next = five_bank & rom_bank_mask_reg;
                    end
                end
                REG_RAM_BANK:
                begin
                    target_next = TGT_CTRL_WR;
                    if (mapper_kind_reg == KIND_ONE)
                    begin
                        if (wide_mode_reg)
                            ram_bank_next = s1_byte_reg & ram_bank_mask_reg;
                    end
                    else
                    begin
                        ram_bank_next = s1_byte_reg & ram_bank_mask_reg;
                        if (has_motor_reg && motor_allowed_reg && s1_byte_reg[3])
                            motor_flag_next = 1'b1;
                        if (has_clock_reg)
                            clock_sel_next = s1_byte_reg[SEL_W-1:0];
                    end
                end
                REG_MODE:
                begin
                    target_next = TGT_CTRL_WR;
                    if (mapper_kind_reg == KIND_ONE)
                    begin
                        if (s1_byte_reg == 8'd0)
                            wide_mode_next = 1'b0;
                        else if (s1_byte_reg == 8'd1)
                            wide_mode_next = 1'b1;
                    end
                    else if (has_clock_reg)
                    begin
                        latch_en        = !latch_last_reg && (s1_byte_reg != '0);
                        latch_last_next = (s1_byte_reg != '0);
                    end
                end
                REG_EXT_RAM:
                begin
                    if (!ram_enabled_reg)
                    begin
                        target_next    = TGT_DISABLED;
                        read_byte_next = '1;
                    end
                    else if (clock_mapped)
                    begin
                        target_next = TGT_CLK_WR;
                        clk_wr_en   = sel_ok;
                        case (sel)
                            SEL_SEC, SEL_MIN: clk_wr_data = mod60(s1_byte_reg);
                            SEL_HOUR:         clk_wr_data = mod24(s1_byte_reg);
                            default:          clk_wr_data = s1_byte_reg;
                        endcase
                    end
                    else
                    begin
                        target_next = TGT_RAM_WR;
                        phys_next   = PHYS_W'({ram_bank_reg, s1_addr_reg[12:0]});
                    end
                end
                default: ;
            endcase
        end
    end

    // Bank state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg <= 1'b0;
            rom_bank_reg    <= ROM_BANK_W'(1);
            ram_bank_reg    <= '0;
            wide_mode_reg   <= 1'b0;
            low_half_reg    <= '0;
            high_bit_reg    <= 1'b0;
            clock_sel_reg   <= '0;
            latch_last_reg  <= 1'b0;
            motor_flag_reg  <= 1'b0;
        end
        else if (advance)
        begin
            ram_enabled_reg <= ram_enabled_next;
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            wide_mode_reg   <= wide_mode_next;
            low_half_reg    <= low_half_next;
            high_bit_reg    <= high_bit_next;
            clock_sel_reg   <= clock_sel_next;
            latch_last_reg  <= latch_last_next;
            motor_flag_reg  <= motor_flag_next;
        end
    end

    // Clock registers and latched copy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLOCK_REGS; i++)
            begin
                clock_regs_reg[i] <= '0;
                clock_held_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < CLOCK_REGS; i++)
            begin
                if (clk_wr_en && sel == CLK_IDX_W'(i))
                    clock_regs_reg[i] <= clk_wr_data;
                if (latch_en)
                    clock_held_reg[i] <= clock_regs_reg[i];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            target_reg    <= target_next;
            phys_reg      <= phys_next;
            read_byte_reg <= read_byte_next;
            motor_out_reg <= motor_flag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign target       = target_reg;
    assign phys_address = phys_reg;
    assign read_byte    = read_byte_reg;
    assign motor_on     = motor_out_reg;

endmodule
